// File: rtl/dpod_pkg.sv
// shared types, constants and calendar helpers for the date period overlap block
package dpod_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 22;
   localparam int REQ_W   = 96;
   localparam int RSP_W   = 24;
   localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
   localparam int PAD_W   = REQ_W - 4 * DATE_W;

   // year counter carries one extra bit: the first step may leave the top year
   localparam int CUR_YEAR_W = YEAR_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
   localparam logic [YEAR_W-1:0]  GREG_CYCLE = YEAR_W'(400);
   localparam logic [YEAR_W-1:0]  CENT_1 = YEAR_W'(100);
   localparam logic [YEAR_W-1:0]  CENT_2 = YEAR_W'(200);
   localparam logic [YEAR_W-1:0]  CENT_3 = YEAR_W'(300);
   localparam logic [YEAR_W-1:0]  GREG_LAST = YEAR_W'(399);
   localparam logic [MONTH_W:0]   LAST_MONTH = (MONTH_W+1)'(12);

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // date as it travels on tdata: year in the lowest bits
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic [PAD_W-1:0] pad;
      date_type         second_end;
      date_type         second_start;
      date_type         first_end;
      date_type         first_start;
   } req_payload_type;

   typedef struct packed {
      logic load;
      logic reduce;
      logic step;
      logic finish;
   } dpod_cmd_type;

   typedef struct packed {
      logic rem_ge_cycle;
      logic step_more;
      logic out_busy;
   } dpod_status_type;

   // ordering key: year, then month, then day
   function automatic logic [DATE_W-1:0] date_key(input date_type d);
      return {d.year, d.month, d.day};
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      len = '0;
      if (m >= MONTH_W'(1) && m <= MONTH_W'(12)) begin
         if (m == MONTH_W'(2) && leap) begin
            len = DAY_W'(29);
         end else begin
            len = MONTH_LEN[m - MONTH_W'(1)];
         end
      end
      return len;
   endfunction

endpackage

// File: rtl/date_period_overlap_days.sv
// Overlap of two Gregorian date periods, counted by stepping one day per clock.
// Each request transfer carries two periods; the result says whether they overlap
// (touching counts) and how many days lie from the later start to the earlier end,
// end day excluded, saturating at 4194303. Each item is loaded on its transfer, then
// the start year is reduced modulo 400 for leap tracking (one subtraction of 400 per
// cycle), then the days are stepped, then the result is written to the output register
// once the previous result has left it or is being taken. Out-of-range dates are not
// flagged. A new request is taken once the previous result sits in the output
// register, even if that result has not yet been transferred.
module date_period_overlap_days
   import dpod_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // first_start_year, _month, _day, first_end_year, _month, _day,
   // second_start_year, _month, _day, second_end_year, _month, _day, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // overlaps, overlap_days, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   dpod_cmd_type    cmd;
   dpod_status_type status;

   dpod_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dpod_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/dpod_ctrl.sv
// controller: sequences load, year reduction, day stepping and result hand-off
module dpod_ctrl
   import dpod_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  dpod_status_type status,
   output dpod_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.rem_ge_cycle) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.step_more) begin
               cmd.step = 1'b1;
            end else if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/dpod_datapath.sv
// datapath: period compare, date stepper with leap tracking, day counter, result register
module dpod_datapath
   import dpod_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dpod_cmd_type    cmd,
   output dpod_status_type status,
   input  logic [REQ_W-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   req_payload_type req;
   logic            ov;
   date_type        later_start;
   date_type        earlier_end;

   logic [CUR_YEAR_W-1:0] cur_year_ff, cur_year_in;
   logic [MONTH_W-1:0]    cur_month_ff, cur_month_in;
   logic [DAY_W-1:0]      cur_day_ff, cur_day_in;
   logic [YEAR_W-1:0]     rem_ff, rem_in;
   date_type              end_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  ov_ff;
   logic                  skip_ff;
   logic                  rsp_valid_ff;
   logic [RSP_W-1:0]      rsp_data_ff;

   logic                  leap;
   logic [DAY_W-1:0]      mlen;
   logic [DAY_W:0]        day_nx;
   logic [MONTH_W:0]      month_nx;
   logic                  cur_before_end;

   assign req = req_payload_type'(req_tdata);

   // periods overlap unless one starts after the other ends
   assign ov = !((date_key(req.second_start) > date_key(req.first_end)) ||
                 (date_key(req.first_start) > date_key(req.second_end)));
   assign later_start = (date_key(req.first_start) > date_key(req.second_start)) ?
                        req.first_start : req.second_start;
   assign earlier_end = (date_key(req.first_end) < date_key(req.second_end)) ?
                        req.first_end : req.second_end;

   // rem is the year modulo 400 once reduction is done
   assign leap = (rem_ff[1:0] == 2'b00) && (rem_ff != CENT_1) && (rem_ff != CENT_2) &&
                 (rem_ff != CENT_3);
   assign mlen = month_days(cur_month_ff, leap);

   always_comb begin
      day_nx       = {1'b0, cur_day_ff} + (DAY_W+1)'(1);
      month_nx     = {1'b0, cur_month_ff};
      cur_day_in   = day_nx[DAY_W-1:0];
      cur_year_in  = cur_year_ff;
      cur_month_in = cur_month_ff;
      rem_in       = rem_ff;
      if (day_nx > {1'b0, mlen}) begin
         month_nx   = {1'b0, cur_month_ff} + (MONTH_W+1)'(1);
         cur_day_in = DAY_W'(1);
      end
      // invalid months also roll into the next year here
      if (month_nx > LAST_MONTH) begin
         cur_year_in  = cur_year_ff + CUR_YEAR_W'(1);
         cur_month_in = MONTH_W'(1);
         rem_in       = (rem_ff == GREG_LAST) ? '0 : rem_ff + YEAR_W'(1);
      end else begin
         cur_month_in = month_nx[MONTH_W-1:0];
      end
   end

   assign cur_before_end = {cur_year_ff, cur_month_ff, cur_day_ff} <
                           {1'b0, date_key(end_ff)};

   assign status.rem_ge_cycle = (rem_ff >= GREG_CYCLE);
   assign status.step_more    = !skip_ff && (count_ff != COUNT_SAT) &&
                                ((count_ff == '0) || cur_before_end);
   assign status.out_busy     = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_year_ff  <= {1'b0, later_start.year};
         cur_month_ff <= later_start.month;
         cur_day_ff   <= later_start.day;
         rem_ff       <= later_start.year;
         end_ff       <= earlier_end;
         count_ff     <= '0;
         ov_ff        <= ov;
         skip_ff      <= !ov || (date_key(later_start) >= date_key(earlier_end));
      end else if (cmd.reduce) begin
         rem_ff <= rem_ff - GREG_CYCLE;
      end else if (cmd.step) begin
         cur_year_ff  <= cur_year_in;
         cur_month_ff <= cur_month_in;
         cur_day_ff   <= cur_day_in;
         rem_ff       <= rem_in;
         count_ff     <= count_ff + COUNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_data_ff <= {1'b0, count_ff, ov_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: dv/tb_date_period_overlap_days.sv
// self-checking testbench for the date period overlap block on its request and result streams
`timescale 1ns / 1ps

module tb_date_period_overlap_days;
   import dpod_pkg::*;

   localparam int          RANDOM_ITEMS = 100;
   localparam int unsigned TOP_YEAR     = (1 << YEAR_W) - 1;

   typedef struct packed {
      logic [COUNT_W-1:0] days;
      logic               overlaps;
   } overlap_result_t;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_CHOPPY,
      RX_HELD
   } rx_mode_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // first_start_year, _month, _day, first_end_year, _month, _day,
   // second_start_year, _month, _day, second_end_year, _month, _day, zero pad
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // overlaps, overlap_days, zero pad
   logic [RSP_W-1:0] rsp_tdata;

   overlap_result_t expected_overlaps [$];
   int              failures = 0;
   int              items_sent = 0;
   int              results_checked = 0;
   int              overlapping_seen = 0;
   int              saturated_seen = 0;
   int              burst_left = 0;
   rx_mode_t        rx_mode = RX_STEADY;
   int              rx_phase_left = 0;

   date_period_overlap_days dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- calendar
   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // zero for month codes outside 1..12
   function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
      if (m < 1 || m > 12) return 0;
      case (m)
         2:          return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   // count of real calendar dates from year 0 that lie strictly before (y, m, d)
   function automatic longint unsigned calendar_ordinal(int unsigned y, int unsigned m,
                                                        int unsigned d);
      longint unsigned n;
      int unsigned     whole;
      int unsigned     dd;
      int unsigned     ml;
      n = 365 * longint'(y) + longint'((y + 3) / 4) - longint'((y + 99) / 100)
          + longint'((y + 399) / 400);
      whole = (m == 0) ? 0 : m - 1;
      if (whole > 12) whole = 12;
      for (int unsigned i = 1; i <= whole; i++) n += days_in_month(y, i);
      if (m >= 1 && m <= 12) begin
         dd = (d == 0) ? 0 : d - 1;
         ml = days_in_month(y, m);
         n += (dd < ml) ? dd : ml;
      end
      return n;
   endfunction

   // raw year/month/day order, also for dates that do not exist
   function automatic logic [DATE_W-1:0] date_rank(date_type d);
      return {d.year, d.month, d.day};
   endfunction

   function automatic overlap_result_t predict_overlap(req_payload_type p);
      overlap_result_t r;
      date_type        late_start;
      date_type        early_end;
      int unsigned     ny;
      int unsigned     nm;
      int unsigned     nd;
      longint unsigned stop_n;
      longint unsigned from_n;
      longint unsigned cnt;
      cnt = 0;
      r.overlaps = !(date_rank(p.second_start) > date_rank(p.first_end) ||
                     date_rank(p.first_start) > date_rank(p.second_end));
      if (r.overlaps) begin
         late_start = (date_rank(p.first_start) > date_rank(p.second_start)) ?
                      p.first_start : p.second_start;
         early_end  = (date_rank(p.first_end) < date_rank(p.second_end)) ?
                      p.first_end : p.second_end;
         if (date_rank(late_start) < date_rank(early_end)) begin
            // the first day step also pulls an impossible start onto a real date
            ny = late_start.year;
            nm = late_start.month;
            nd = late_start.day + 1;
            if (nd > days_in_month(ny, nm)) begin
               nm++;
               nd = 1;
            end
            if (nm > 12) begin
               ny++;
               nm = 1;
            end
            stop_n = calendar_ordinal(early_end.year, early_end.month, early_end.day);
            from_n = calendar_ordinal(ny, nm, nd);
            cnt = 1 + ((stop_n > from_n) ? stop_n - from_n : 0);
         end
      end
      if (cnt > COUNT_SAT) cnt = COUNT_SAT;
      r.days = cnt[COUNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic date_type mk_date(int unsigned y, int unsigned m, int unsigned d);
      date_type r;
      r.year  = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day   = DAY_W'(d);
      return r;
   endfunction

   // walks a real date forward n days
   function automatic date_type step_days(date_type d, int unsigned n);
      int unsigned y;
      int unsigned m;
      int unsigned dd;
      y  = d.year;
      m  = d.month;
      dd = d.day;
      repeat (n) begin
         dd++;
         if (dd > days_in_month(y, m)) begin
            dd = 1;
            m++;
            if (m > 12) begin
               m = 1;
               y++;
            end
         end
      end
      return mk_date(y, m, dd);
   endfunction

   function automatic date_type random_real_date();
      int unsigned sel;
      int unsigned y;
      int unsigned m;
      sel = $urandom_range(0, 9);
      if (sel < 6) y = $urandom_range(0, 9999);
      else if (sel < 8) y = 100 * $urandom_range(1, 99) - 1 + $urandom_range(0, 2);
      else y = $urandom_range(10000, TOP_YEAR - 13);
      m = $urandom_range(1, 12);
      return mk_date(y, m, $urandom_range(1, days_in_month(y, m)));
   endfunction

   // mostly short periods so the day stepper stays quick
   function automatic int unsigned random_span();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return $urandom_range(0, 60);
      if (sel < 19) return $urandom_range(61, 400);
      return $urandom_range(401, 1500);
   endfunction

   task automatic send_periods(input date_type s1, input date_type e1,
                               input date_type s2, input date_type e2);
      req_payload_type p;
      int              idle_cycles;
      p.pad          = '0;
      p.first_start  = s1;
      p.first_end    = e1;
      p.second_start = s2;
      p.second_end   = e2;
      if (burst_left == 0) begin
         idle_cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 4);
         if (idle_cycles != 0) begin
            req_tvalid <= 1'b0;
            repeat (idle_cycles) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_overlaps.push_back(predict_overlap(p));
      items_sent++;
   endtask

   // ---------------------------------------------------------------- result check
   always @(posedge clock) begin : rsp_check
      overlap_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_overlaps.size() == 0) begin
            $error("result transfer with no request outstanding: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = expected_overlaps.pop_front();
            results_checked++;
            if (want.overlaps) overlapping_seen++;
            if (want.days == COUNT_SAT) saturated_seen++;
            if (rsp_tdata[0] !== want.overlaps) begin
               $error("overlaps: expected %0d, got %0d", want.overlaps, rsp_tdata[0]);
               failures++;
            end
            if (rsp_tdata[COUNT_W:1] !== want.days) begin
               $error("overlap_days: expected %0d, got %0d", want.days,
                      rsp_tdata[COUNT_W:1]);
               failures++;
            end
         end
      end
      // receiver back-pressure runs in phases: always ready, chopped, or held off
      if (rx_phase_left == 0) begin
         rx_mode = rx_mode_t'($urandom_range(0, 2));
         rx_phase_left = $urandom_range(6, 40);
      end
      rx_phase_left--;
      case (rx_mode)
         RX_STEADY: rsp_tready <= 1'b1;
         RX_CHOPPY: rsp_tready <= ($urandom_range(0, 2) != 0);
         default:   rsp_tready <= 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- tests
   task automatic test_disjoint_and_touching();
      send_periods(mk_date(2001, 3, 1), mk_date(2001, 3, 10),
                   mk_date(2001, 3, 11), mk_date(2001, 3, 20));
      send_periods(mk_date(2001, 3, 11), mk_date(2001, 3, 20),
                   mk_date(2001, 3, 1), mk_date(2001, 3, 10));
      send_periods(mk_date(2001, 3, 1), mk_date(2001, 3, 10),
                   mk_date(2001, 3, 10), mk_date(2001, 3, 20));
      send_periods(mk_date(2001, 7, 4), mk_date(2001, 7, 4),
                   mk_date(2001, 7, 4), mk_date(2001, 7, 4));
      send_periods(mk_date(2001, 3, 1), mk_date(2001, 3, 15),
                   mk_date(2001, 3, 10), mk_date(2001, 3, 31));
      send_periods(mk_date(2001, 1, 1), mk_date(2001, 12, 31),
                   mk_date(2001, 5, 5), mk_date(2001, 6, 6));
   endtask

   task automatic test_leap_rules();
      // divisible by 400, by 100 only, by 4 only
      send_periods(mk_date(2000, 2, 27), mk_date(2000, 3, 2),
                   mk_date(2000, 2, 1), mk_date(2000, 3, 31));
      send_periods(mk_date(1900, 2, 27), mk_date(1900, 3, 2),
                   mk_date(1900, 2, 1), mk_date(1900, 3, 31));
      send_periods(mk_date(2004, 2, 27), mk_date(2004, 3, 2),
                   mk_date(2004, 2, 1), mk_date(2004, 3, 31));
      send_periods(mk_date(0, 1, 1), mk_date(0, 3, 1), mk_date(0, 1, 1), mk_date(0, 3, 1));
      send_periods(mk_date(1999, 12, 30), mk_date(2000, 1, 2),
                   mk_date(1999, 12, 1), mk_date(2000, 1, 31));
      send_periods(mk_date(1999, 6, 15), mk_date(2003, 2, 10),
                   mk_date(1998, 1, 1), mk_date(2004, 1, 1));
   endtask

   task automatic test_impossible_dates();
      send_periods(mk_date(2001, 0, 5), mk_date(2001, 1, 3),
                   mk_date(2000, 1, 1), mk_date(2002, 1, 1));
      send_periods(mk_date(2001, 13, 1), mk_date(2002, 1, 2),
                   mk_date(2001, 13, 1), mk_date(2002, 1, 2));
      send_periods(mk_date(2001, 3, 0), mk_date(2001, 3, 2),
                   mk_date(2001, 3, 0), mk_date(2001, 3, 2));
      send_periods(mk_date(2001, 4, 31), mk_date(2001, 5, 3),
                   mk_date(2001, 4, 1), mk_date(2001, 5, 30));
      send_periods(mk_date(2001, 2, 27), mk_date(2001, 2, 30),
                   mk_date(2001, 2, 1), mk_date(2001, 3, 30));
      // first period runs backwards
      send_periods(mk_date(2001, 5, 10), mk_date(2001, 5, 1),
                   mk_date(2001, 5, 1), mk_date(2001, 5, 20));
   endtask

   task automatic test_field_extremes();
      send_periods(mk_date(0, 0, 0), mk_date(0, 0, 0), mk_date(0, 0, 0), mk_date(0, 0, 0));
      send_periods(mk_date(TOP_YEAR, 15, 31), mk_date(TOP_YEAR, 15, 31),
                   mk_date(TOP_YEAR, 15, 31), mk_date(TOP_YEAR, 15, 31));
      // first step leaves the top representable year
      send_periods(mk_date(TOP_YEAR, 12, 31), mk_date(TOP_YEAR, 15, 31),
                   mk_date(TOP_YEAR, 12, 31), mk_date(TOP_YEAR, 15, 31));
      send_periods(mk_date(9999, 12, 30), mk_date(9999, 12, 31),
                   mk_date(9998, 1, 1), mk_date(9999, 12, 31));
   endtask

   // just past the 22-bit count: the day stepper runs until the count saturates
   task automatic test_saturation();
      send_periods(mk_date(0, 1, 1), mk_date(11484, 1, 1),
                   mk_date(0, 1, 1), mk_date(11484, 1, 1));
   endtask

   task automatic test_random_periods();
      date_type    anchor;
      date_type    s1;
      date_type    e1;
      date_type    s2;
      date_type    e2;
      date_type    hold;
      int unsigned kind;
      int unsigned base_year;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // raw field noise, years kept close so the count stays short
            base_year = $urandom_range(0, TOP_YEAR - 1);
            s1 = mk_date(base_year + $urandom_range(0, 1), $urandom_range(0, 15),
                         $urandom_range(0, 31));
            e1 = mk_date(base_year + $urandom_range(0, 1), $urandom_range(0, 15),
                         $urandom_range(0, 31));
            s2 = mk_date(base_year + $urandom_range(0, 1), $urandom_range(0, 15),
                         $urandom_range(0, 31));
            e2 = mk_date(base_year + $urandom_range(0, 1), $urandom_range(0, 15),
                         $urandom_range(0, 31));
         end else begin
            anchor = random_real_date();
            s1 = step_days(anchor, $urandom_range(0, 30));
            s2 = step_days(anchor, $urandom_range(0, 30));
            e1 = step_days(s1, random_span());
            e2 = step_days(s2, random_span());
            if (kind == 1) s2 = e1;
            if (kind == 2) begin
               hold = s1;
               s1   = e1;
               e1   = hold;
            end
         end
         send_periods(s1, e1, s2, e2);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_disjoint_and_touching();
      test_leap_rules();
      test_impossible_dates();
      test_field_extremes();
      test_saturation();
      test_random_periods();
      req_tvalid <= 1'b0;
      while (expected_overlaps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d period pairs, %0d results checked", items_sent, results_checked);
      $display("%0d pairs overlapped, %0d counts hit the 22-bit ceiling",
               overlapping_seen, saturated_seen);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // the saturating pair alone keeps the day stepper busy until its count saturates
   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
rtl/dpod_pkg.sv
rtl/dpod_ctrl.sv
rtl/dpod_datapath.sv
rtl/date_period_overlap_days.sv
dv/tb_date_period_overlap_days.sv
